// ===== design/merge_sort_inversion_counter_top_macros.svh =====
// assertion macros for the merge sort inversion counter
// used by merge_sort_inversion_counter_top; expects signals clock and reset in scope
`ifndef MERGE_SORT_INVERSION_COUNTER_TOP_MACROS_SVH
`define MERGE_SORT_INVERSION_COUNTER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define MSIC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MSIC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/msic_pkg.sv =====
// shared types and constants for the merge sort inversion counter
// no dependencies; imported by msic_stores and merge_sort_inversion_counter_top
package msic_pkg;

   localparam int MAX_ITEMS_DEFAULT = 1024;
   localparam int VALUE_W           = 32;
   localparam int INV_W             = 19;

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_PRIME = 4'b0010,
      ST_MERGE = 4'b0100,
      ST_DONE  = 4'b1000
   } msic_state_type;

   typedef struct packed {
      logic wr_en;
      logic wr_to_b;
      logic rd_from_b;
   } msic_mem_ctl_type;

endpackage

// ===== design/msic_stores.sv =====
// value store and scratch store, used as ping-pong buffers for the merge passes
// depends on msic_pkg; one write port, two registered read ports per store
module msic_stores #(
   parameter int MAX_ITEMS = msic_pkg::MAX_ITEMS_DEFAULT,
   localparam int AW = $clog2(MAX_ITEMS)
) (
   input  logic                                 clock,
   input  msic_pkg::msic_mem_ctl_type           ctl,
   input  logic [AW-1:0]                        wr_addr,
   input  logic signed [msic_pkg::VALUE_W-1:0]  wr_data,
   input  logic [AW-1:0]                        rd_addr_i,
   input  logic [AW-1:0]                        rd_addr_j,
   output logic signed [msic_pkg::VALUE_W-1:0]  rd_data_i,
   output logic signed [msic_pkg::VALUE_W-1:0]  rd_data_j
);
   import msic_pkg::*;

   logic signed [VALUE_W-1:0] value_store_ff   [MAX_ITEMS];
   logic signed [VALUE_W-1:0] scratch_store_ff [MAX_ITEMS];
   logic signed [VALUE_W-1:0] val_i_ff, val_j_ff, scr_i_ff, scr_j_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en && !ctl.wr_to_b) begin
         value_store_ff[wr_addr] <= wr_data;
      end
      val_i_ff <= value_store_ff[rd_addr_i];
      val_j_ff <= value_store_ff[rd_addr_j];
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en && ctl.wr_to_b) begin
         scratch_store_ff[wr_addr] <= wr_data;
      end
      scr_i_ff <= scratch_store_ff[rd_addr_i];
      scr_j_ff <= scratch_store_ff[rd_addr_j];
   end

   // select follows the pass direction of the cycle the data is used in
   assign rd_data_i = ctl.rd_from_b ? scr_i_ff : val_i_ff;
   assign rd_data_j = ctl.rd_from_b ? scr_j_ff : val_j_ff;

endmodule

// ===== design/merge_sort_inversion_counter_top.sv =====
// top level of the merge sort inversion counter: load, merge sequencer, result register
// depends on msic_pkg, msic_stores and merge_sort_inversion_counter_top_macros.svh
//
//   channel | ports                                     | direction
//   req     | req_valid req_stall req_value req_is_last | in  (one element per item)
//   rsp     | rsp_valid rsp_stall rsp_inversions        | out (one count per sequence)
//
// loading stores each accepted item while there is room; the last item starts the sort
// sorting n items takes ceil(log2 n) passes, each a prime state and then one merge step per
//   cycle through the two read ports of the source store; the sort ends in done
// req_stall is high from the last item until the count is handed to the result register
// reset clears the item counter, the running total, the sequencer and rsp_valid
// the result register holds under rsp_stall while the next sequence loads
module merge_sort_inversion_counter_top #(
   parameter int MAX_ITEMS = msic_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [msic_pkg::VALUE_W-1:0]  req_value,
   input  logic                                 req_is_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [msic_pkg::INV_W-1:0]           rsp_inversions
);
   import msic_pkg::*;

   `include "merge_sort_inversion_counter_top_macros.svh"

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int WW = CW + 1;
   localparam int SW = CW + 2;
   localparam int DW = (CW > INV_W) ? CW : INV_W;

   msic_state_type       state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CW-1:0]        mid_ff, mid_in, hi_ff, hi_in;
   logic [WW-1:0]        w_ff, w_in;
   logic                 dir_ff, dir_in;
   logic [INV_W-1:0]     total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [INV_W-1:0]     rsp_inv_ff, rsp_inv_in;

   msic_mem_ctl_type     mem_ctl;
   logic [AW-1:0]        wr_addr;
   logic signed [VALUE_W-1:0] wr_data;
   logic signed [VALUE_W-1:0] rd_i, rd_j;

   logic                 req_accept, room, slot_free;
   logic [CW-1:0]        load_n, k_next;
   logic                 left_done, right_done, greater, take_j, seg_end, pass_end;
   logic [WW-1:0]        w_dbl;
   logic [SW-1:0]        seg_lo, seg_w, seg_n, mid_sum, hi_sum;
   logic [CW-1:0]        mid_c, hi_c;
   logic [DW-1:0]        run_left;
   logic                 chk_merge, chk_bounds, chk_balance, chk_hand_off, chk_handed;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_LOAD);
   assign room       = (count_ff < CW'(MAX_ITEMS));
   assign load_n     = room ? (count_ff + CW'(1)) : count_ff;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   // merge step on the heads of both runs
   assign left_done  = (i_ff >= mid_ff);
   assign right_done = (j_ff >= hi_ff);
   assign greater    = (rd_i > rd_j);
   assign take_j     = left_done || (!right_done && greater);
   assign k_next     = k_ff + CW'(1);
   assign seg_end    = (k_next == hi_ff);
   assign pass_end   = seg_end && (hi_ff == count_ff);
   assign w_dbl      = w_ff << 1;
   assign run_left   = DW'(mid_ff) - DW'(i_ff);

   // bounds of the next segment: first of a sort, first of a pass, or the following one
   always_comb begin
      if (state_ff == ST_LOAD) begin
         seg_lo = '0;
         seg_w  = SW'(1);
         seg_n  = SW'(load_n);
      end else begin
         seg_lo = pass_end ? '0 : SW'(hi_ff);
         seg_w  = pass_end ? SW'(w_dbl) : SW'(w_ff);
         seg_n  = SW'(count_ff);
      end
      mid_sum = seg_lo + seg_w;
      hi_sum  = seg_lo + (seg_w << 1);
      mid_c   = (mid_sum < seg_n) ? mid_sum[CW-1:0] : seg_n[CW-1:0];
      hi_c    = (hi_sum < seg_n) ? hi_sum[CW-1:0] : seg_n[CW-1:0];
   end

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      i_in              = i_ff;
      j_in              = j_ff;
      k_in              = k_ff;
      mid_in            = mid_ff;
      hi_in             = hi_ff;
      w_in              = w_ff;
      dir_in            = dir_ff;
      total_in          = total_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_inv_in        = rsp_inv_ff;
      mem_ctl.wr_en     = 1'b0;
      mem_ctl.wr_to_b   = !dir_ff;
      mem_ctl.rd_from_b = dir_ff;
      wr_addr           = k_ff[AW-1:0];
      wr_data           = take_j ? rd_j : rd_i;

      unique case (state_ff)
         ST_LOAD: begin
            wr_addr         = count_ff[AW-1:0];
            wr_data         = req_value;
            mem_ctl.wr_to_b = 1'b0;
            if (req_accept) begin
               mem_ctl.wr_en = room;
               count_in      = load_n;
               if (req_is_last) begin
                  total_in = '0;
                  dir_in   = 1'b0;
                  w_in     = WW'(1);
                  i_in     = '0;
                  k_in     = '0;
                  j_in     = mid_c;
                  mid_in   = mid_c;
                  hi_in    = hi_c;
                  state_in = (load_n <= CW'(1)) ? ST_DONE : ST_PRIME;
               end
            end
         end
         ST_PRIME: begin
            // reads of this cycle see the last write of the previous pass
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            mem_ctl.wr_en = 1'b1;
            if (!left_done && !right_done && greater) begin
               total_in = total_ff + run_left[INV_W-1:0];
            end
            i_in = take_j ? i_ff : (i_ff + CW'(1));
            j_in = take_j ? (j_ff + CW'(1)) : j_ff;
            k_in = k_next;
            if (seg_end) begin
               i_in   = seg_lo[CW-1:0];
               k_in   = seg_lo[CW-1:0];
               j_in   = mid_c;
               mid_in = mid_c;
               hi_in  = hi_c;
               if (pass_end) begin
                  w_in     = w_dbl;
                  dir_in   = !dir_ff;
                  state_in = (w_dbl >= WW'(count_ff)) ? ST_DONE : ST_PRIME;
               end
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_inv_in   = total_ff;
               count_in     = '0;
               total_in     = '0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      mid_ff     <= mid_in;
      hi_ff      <= hi_in;
      w_ff       <= w_in;
      dir_ff     <= dir_in;
      rsp_inv_ff <= rsp_inv_in;
   end

   msic_stores #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_stores (
      .clock     (clock),
      .ctl       (mem_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_i (i_in[AW-1:0]),
      .rd_addr_j (j_in[AW-1:0]),
      .rd_data_i (rd_i),
      .rd_data_j (rd_j)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inversions = rsp_inv_ff;

   assign chk_merge    = (state_ff == ST_MERGE);
   assign chk_bounds   = (k_ff < hi_ff) && (i_ff <= mid_ff) && (j_ff <= hi_ff);
   assign chk_balance  = ((k_ff + mid_ff) == (i_ff + j_ff));
   assign chk_hand_off = (state_ff == ST_DONE) && slot_free;
   assign chk_handed   = rsp_valid_ff && (state_ff == ST_LOAD);

   `MSIC_ASSERT_SAME(a_merge_bounds, chk_merge, chk_bounds, "merge index outside its segment")
   `MSIC_ASSERT_SAME(a_merge_conserve, chk_merge, chk_balance, "merge indexes out of step")
   `MSIC_ASSERT_SAME(a_count_limit, 1'b1, count_ff <= CW'(MAX_ITEMS), "item counter past depth")
   `MSIC_ASSERT_NEXT(a_done_delivers, chk_hand_off, chk_handed, "count not moved to result register")

endmodule
